@@ src/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int PTR_W      = $clog2(CELL_COUNT + 1);
  localparam int CELL_W     = 16;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int COLOR_W    = 4;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

@@ src/text_console_writer.sv @@
// Text console writer: a character screen of ROWS x COLUMNS 16-bit cells.
// Command channel (in_valid_i / in_stall_o) takes opcode_i, char_code_i and
// cell_index_i; a beat moves when valid is high and stall is low. Every
// command gives exactly one result beat on out_valid_o / out_stall_i with
// the cursor after the command, the read cell value and an index flag.
// Config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 sets
// the foreground nibble, index 1 the background nibble. Write it only
// while no command is in flight.
// A printable character, tab, return or newline without scroll goes
// straight to ST_DONE; a cell read first passes through ST_READ for the
// RAM read (an out-of-range index skips it); clear writes every cell,
// one cell write per cycle through the single write port; a scroll
// copies every cell below the top row one row up and then blanks the
// bottom row.
// One command is worked on at a time; a new command is taken while the
// previous result still waits in the output register. If the receiver
// stalls, the finished result is held and command intake stops.
// After reset a clearing pass writes 0x0720 to all CELL_COUNT cells,
// one per cycle, with in_stall_o high; config writes are taken meanwhile.
`default_nettype none
module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [CHAR_W-1:0]  char_code_i,
  input  wire logic [IDX_W-1:0]   cell_index_i,

  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [ROW_W-1:0]   cursor_row_o,
  output      logic [COL_W-1:0]   cursor_column_o,
  output      logic [CELL_W-1:0]  cell_value_o,
  output      logic               index_invalid_o,

  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [COLOR_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic               rdv_q, rdv_d;
  logic [CELL_W-1:0]  val_q, val_d;
  logic               inv_q, inv_d;
  logic [COLOR_W-1:0] fg_q, bg_q;

  logic               out_valid_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic [CELL_W-1:0]  out_val_q;
  logic               out_inv_q;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic [ADDR_W-1:0]  cell_addr;
  logic [CHAR_W-1:0]  col_inc;
  logic [CHAR_W-1:0]  tab_col;
  logic               nl_req;
  logic               last_row;
  logic               scroll_req;
  logic               idx_bad;
  logic [CELL_W-1:0]  blank_cell;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;
  assign cfg_ready_o = 1'b1;

  assign blank_cell = {bg_q, fg_q, CH_SPACE};
  assign cell_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign col_inc    = CHAR_W'(col_q) + CHAR_W'(1);
  assign tab_col    = (CHAR_W'(col_q) + CHAR_W'(8)) & ~CHAR_W'(7);
  assign last_row   = (row_q == ROW_W'(ROWS - 1));
  assign idx_bad    = (cell_index_i >= IDX_W'(CELL_COUNT));

  always_comb begin
    case (char_code_i)
      CH_NEWLINE: nl_req = 1'b1;
      CH_RETURN:  nl_req = 1'b0;
      CH_TAB:     nl_req = (tab_col >= CHAR_W'(COLUMNS));
      default:    nl_req = (col_inc >= CHAR_W'(COLUMNS));
    endcase
  end

  assign scroll_req = (opcode_i == OP_PUT) && nl_req && last_row;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (ptr_q == PTR_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_PUT:   state_d = scroll_req ? ST_SCROLL : ST_DONE;
            OP_CLEAR: state_d = ST_FILL;
            OP_READ:  state_d = idx_bad ? ST_DONE : ST_READ;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_SCROLL: begin
        if (ptr_q == PTR_W'(CELL_COUNT)) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (ptr_q == PTR_W'(CELL_COUNT - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    ptr_d     = ptr_q;
    rdv_d     = 1'b0;
    val_d     = val_q;
    inv_d     = inv_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = blank_cell;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[ADDR_W-1:0];
        ram_wdata = RESET_BLANK;
        ptr_d     = ptr_q + PTR_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          val_d = '0;
          inv_d = 1'b0;
          case (opcode_i)
            OP_PUT: begin
              if (char_code_i == CH_RETURN) begin
                col_d = '0;
              end else if (nl_req) begin
                col_d = '0;
                if (!last_row) row_d = row_q + ROW_W'(1);
              end else if (char_code_i == CH_TAB) begin
                col_d = tab_col[COL_W-1:0];
              end else begin
                col_d = col_inc[COL_W-1:0];
              end
              if (char_code_i != CH_RETURN && char_code_i != CH_NEWLINE &&
                  char_code_i != CH_TAB) begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr;
                ram_wdata = {bg_q, fg_q, char_code_i};
              end
              ptr_d = PTR_W'(COLUMNS);
            end
            OP_CLEAR: begin
              row_d = '0;
              col_d = '0;
              ptr_d = '0;
            end
            OP_READ: begin
              if (idx_bad) begin
                inv_d = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cell_index_i[ADDR_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: val_d = ram_rdata;
      ST_SCROLL: begin
        if (ptr_q != PTR_W'(CELL_COUNT)) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[ADDR_W-1:0];
          ptr_d     = ptr_q + PTR_W'(1);
          rdv_d     = 1'b1;
        end else begin
          ptr_d = PTR_W'((ROWS - 1) * COLUMNS);
        end
        if (rdv_q) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(ptr_q - PTR_W'(COLUMNS + 1));
          ram_wdata = ram_rdata;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[ADDR_W-1:0];
        ptr_d     = ptr_q + PTR_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      rdv_q       <= 1'b0;
      fg_q        <= COLOR_W'(7);
      bg_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ptr_q   <= ptr_d;
      rdv_q   <= rdv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FG:  fg_q <= cfg_data_i;
          REG_BG:  bg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    inv_q <= inv_d;
    if (out_load) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_val_q <= val_q;
      out_inv_q <= inv_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_column_o = out_col_q;
  assign cell_value_o    = out_val_q;
  assign index_invalid_o = out_inv_q;

endmodule
`default_nettype wire

@@ src/tcw_ram.sv @@
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
